// ===== hdl/m3i_pkg.sv =====
// Shared widths, sizes and the queue entry type for the 3x3 matrix inverse core.
// Used by every module of the core; depends on nothing.
package m3i_pkg;

    localparam int ELEM_W     = 16;
    localparam int IN_FRAC    = 8;
    localparam int NLANE      = 9;
    localparam int OUT_W      = 32;
    localparam int QBITS      = OUT_W - 1;
    localparam int OUT_SHIFT  = IN_FRAC + 16;
    localparam int OVF_SH     = QBITS - OUT_SHIFT;
    localparam int PROD_W     = 2 * ELEM_W;
    localparam int COF_W      = 2 * ELEM_W + 1;
    localparam int NMAG_W     = 2 * ELEM_W;
    localparam int DET_W      = 3 * ELEM_W + 1;
    localparam int DMAG_W     = 3 * ELEM_W;
    localparam int REM_W      = DMAG_W + 1;
    localparam int CMP_W      = DMAG_W + OVF_SH;
    localparam int MIN_DET_W  = 48;
    localparam logic [MIN_DET_W-1:0] MIN_DET_RST = 48'd17;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;
    localparam int IN_DATA_W  = NLANE * ELEM_W;
    localparam int OUT_DATA_W = NLANE * OUT_W;

    // One classified matrix: adjugate magnitudes with result signs, and the
    // determinant magnitude that divides them.
    typedef struct packed {
        logic                               invertible;
        logic [NLANE-1:0]                   neg;
        logic [NLANE-1:0][NMAG_W-1:0]       num;
        logic [DMAG_W-1:0]                  den;
    } q_entry_t;

endpackage

// ===== hdl/m3i_front.sv =====
// Front part: unpacks a matrix beat, forms cofactors and determinant in three stages,
// and classifies the matrix against the threshold. Depends on m3i_pkg.
module m3i_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [m3i_pkg::IN_DATA_W-1:0]   in_data,
    input  logic [m3i_pkg::MIN_DET_W-1:0]   min_det,
    output logic                            push_valid,
    input  logic                            push_ready,
    output m3i_pkg::q_entry_t               push_entry
);
    import m3i_pkg::*;

    logic signed [ELEM_W-1:0] elem [NLANE];
    logic signed [PROD_W-1:0] pa_next [NLANE];
    logic signed [PROD_W-1:0] pb_next [NLANE];
    logic signed [PROD_W-1:0] pa_reg [NLANE];
    logic signed [PROD_W-1:0] pb_reg [NLANE];
    logic signed [ELEM_W-1:0] row1_reg [3];
    logic signed [ELEM_W-1:0] row2_reg [3];
    logic signed [COF_W-1:0]  cof_next [NLANE];
    logic signed [COF_W-1:0]  cof2_reg [NLANE];
    logic signed [COF_W-1:0]  cof3_reg [NLANE];
    logic signed [DET_W-1:0]  dp_next [3];
    logic signed [DET_W-1:0]  dp_reg [3];
    logic                     v1_reg, v2_reg, v3_reg;
    logic                     adv;
    logic signed [DET_W-1:0]  det;
    logic [DET_W-1:0]         dabs;
    logic [DMAG_W-1:0]        dmag;
    logic                     dneg;

    assign adv      = !(v3_reg && !push_ready);
    assign in_ready = adv;

    always_comb
    begin
        int ra, rb, ca, cb, l;
        for (int x = 0; x < NLANE; x++)
        begin
            elem[x] = in_data[x*ELEM_W +: ELEM_W];
        end
        // Cofactor (i,j) is built from the 2x2 minor that skips row i and column j.
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                ra = (i == 0) ? 1 : 0;
                rb = (i == 2) ? 1 : 2;
                ca = (j == 0) ? 1 : 0;
                cb = (j == 2) ? 1 : 2;
                l  = i * 3 + j;
                pa_next[l] = PROD_W'(elem[ra*3+ca]) * PROD_W'(elem[rb*3+cb]);
                pb_next[l] = PROD_W'(elem[ra*3+cb]) * PROD_W'(elem[rb*3+ca]);
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < NLANE; l++)
        begin
            if (((l / 3) + (l % 3)) % 2 == 1)
                cof_next[l] = COF_W'(pb_reg[l]) - COF_W'(pa_reg[l]);
            else
                cof_next[l] = COF_W'(pa_reg[l]) - COF_W'(pb_reg[l]);
        end
        for (int k = 0; k < 3; k++)
        begin
            dp_next[k] = DET_W'(row2_reg[k]) * DET_W'(cof2_reg[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
            for (int k = 0; k < 3; k++)
            begin
                row1_reg[k] <= elem[k];
                row2_reg[k] <= row1_reg[k];
            end
            cof2_reg <= cof_next;
            cof3_reg <= cof2_reg;
            dp_reg   <= dp_next;
        end
    end

    always_comb
    begin
        logic signed [COF_W-1:0] adj;
        logic [COF_W-1:0]        aabs;
        det  = dp_reg[0] + dp_reg[1] + dp_reg[2];
        dneg = det[DET_W-1];
        dabs = dneg ? DET_W'(-det) : DET_W'(det);
        dmag = dabs[DMAG_W-1:0];
        push_entry.den        = dmag;
        push_entry.invertible = (dmag != '0) && (dmag >= min_det);
        // The inverse is the transpose of the cofactor matrix over det.
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                adj  = cof3_reg[k*3+r];
                aabs = adj[COF_W-1] ? COF_W'(-adj) : COF_W'(adj);
                push_entry.neg[r*3+k] = adj[COF_W-1] ^ dneg;
                push_entry.num[r*3+k] = aabs[NMAG_W-1:0];
            end
        end
    end

    assign push_valid = v3_reg;

endmodule

// ===== hdl/m3i_queue.sv =====
// Short queue that decouples the classifying front part from the divider back part.
// Depends on m3i_pkg.
module m3i_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  m3i_pkg::q_entry_t   push_entry,
    output logic                pop_valid,
    input  logic                pop_ready,
    output m3i_pkg::q_entry_t   pop_entry
);
    import m3i_pkg::*;

    q_entry_t            mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic                do_push, do_pop;

    assign push_ready = (count_reg != QPTR_W'(0) + (QPTR_W+1)'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_entry  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== hdl/m3i_back.sv =====
// Back part: nine pipelined restoring dividers, one quotient bit per stage, with
// overflow saturation and a registered result. Depends on m3i_pkg.
module m3i_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pop_valid,
    output logic                            pop_ready,
    input  m3i_pkg::q_entry_t               pop_entry,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [m3i_pkg::OUT_DATA_W-1:0]  out_data,
    output logic                            out_invertible
);
    import m3i_pkg::*;

    logic                               bv_reg  [QBITS+1];
    logic [NLANE-1:0][REM_W-1:0]        rem_reg [QBITS+1];
    logic [NLANE-1:0][QBITS-1:0]        qt_reg  [QBITS+1];
    logic [NLANE-1:0][NMAG_W-1:0]       num_reg [QBITS+1];
    logic [NLANE-1:0]                   neg_reg [QBITS+1];
    logic [NLANE-1:0]                   ovf_reg [QBITS+1];
    logic [DMAG_W-1:0]                  den_reg [QBITS+1];
    logic                               inv_reg [QBITS+1];
    logic                               out_valid_reg;
    logic [OUT_DATA_W-1:0]              out_data_reg;
    logic                               out_inv_reg;
    logic                               adv;
    logic [NLANE-1:0]                   ovf_next;
    logic [NLANE-1:0][REM_W-1:0]        rem0_next;
    logic [OUT_DATA_W-1:0]              out_data_next;

    assign adv       = !out_valid_reg || out_ready;
    assign pop_ready = adv;

    // A quotient needs more than 31 bits exactly when num >= den * 2^OVF_SH.
    always_comb
    begin
        logic [CMP_W-1:0] nx, dx;
        for (int l = 0; l < NLANE; l++)
        begin
            nx = CMP_W'(pop_entry.num[l]);
            dx = {pop_entry.den, {OVF_SH{1'b0}}};
            ovf_next[l]  = (nx >= dx);
            rem0_next[l] = REM_W'(pop_entry.num[l][NMAG_W-1:OVF_SH]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bv_reg[0] <= 1'b0;
        else if (adv)
            bv_reg[0] <= pop_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= rem0_next;
            qt_reg[0]  <= '0;
            num_reg[0] <= pop_entry.num;
            neg_reg[0] <= pop_entry.neg;
            ovf_reg[0] <= ovf_next;
            den_reg[0] <= pop_entry.den;
            inv_reg[0] <= pop_entry.invertible;
        end
    end

    for (genvar s = 0; s < QBITS; s++)
    begin : g_stage
        localparam int BIT = QBITS - 1 - s;
        logic [NLANE-1:0][REM_W-1:0] rem_next;
        logic [NLANE-1:0][QBITS-1:0] qt_next;

        always_comb
        begin
            logic [REM_W-1:0] trial;
            logic             bit_in;
            for (int l = 0; l < NLANE; l++)
            begin
                if (BIT >= OUT_SHIFT)
                    bit_in = num_reg[s][l][(BIT >= OUT_SHIFT) ? BIT - OUT_SHIFT : 0];
                else
                    bit_in = 1'b0;
                trial       = {rem_reg[s][l][REM_W-2:0], bit_in};
                qt_next[l]  = qt_reg[s][l];
                if (trial >= {1'b0, den_reg[s]})
                begin
                    rem_next[l]     = trial - {1'b0, den_reg[s]};
                    qt_next[l][BIT] = 1'b1;
                end
                else
                begin
                    rem_next[l] = trial;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                bv_reg[s+1] <= 1'b0;
            else if (adv)
                bv_reg[s+1] <= bv_reg[s];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s+1] <= rem_next;
                qt_reg[s+1]  <= qt_next;
                num_reg[s+1] <= num_reg[s];
                neg_reg[s+1] <= neg_reg[s];
                ovf_reg[s+1] <= ovf_reg[s];
                den_reg[s+1] <= den_reg[s];
                inv_reg[s+1] <= inv_reg[s];
            end
        end
    end

    always_comb
    begin
        logic [OUT_W-1:0] mag;
        for (int l = 0; l < NLANE; l++)
        begin
            mag = {1'b0, qt_reg[QBITS][l]};
            if (!inv_reg[QBITS])
                out_data_next[l*OUT_W +: OUT_W] = '0;
            else if (ovf_reg[QBITS][l])
                out_data_next[l*OUT_W +: OUT_W] = neg_reg[QBITS][l]
                    ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
            else
                out_data_next[l*OUT_W +: OUT_W] = neg_reg[QBITS][l] ? (~mag + 1'b1) : mag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= bv_reg[QBITS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
            out_inv_reg  <= inv_reg[QBITS];
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_data       = out_data_reg;
    assign out_invertible = out_inv_reg;

endmodule

// ===== hdl/matrix3x3_inverse_core.sv =====
// Top level of the 3x3 matrix inverse core: threshold register, front part, queue, back part.
// Depends on m3i_pkg, m3i_front, m3i_queue and m3i_back.
//
// Channel   Direction  Handshake          Payload
// s_axis    in         s_tvalid/s_tready  s_tdata: nine Q8.8 matrix entries
// m_axis    out        m_tvalid/m_tready  m_tdata: nine Q16.16 entries, m_tuser: invertible
// cfg       in         cfg_valid/cfg_ready cfg_data: min_det threshold
//
// One matrix beat is accepted per cycle and one result beat leaves per cycle when
// the sink keeps up. An accepted beat passes the front stages, the queue, the
// operand register loaded by the pop, the 31 divider stages and the output register.
// Reset clears all valid flags and the queue and loads min_det with 17. A stalled
// sink freezes the back part only; the front part keeps taking beats until the
// four-entry queue fills.
module matrix3x3_inverse_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // e00, e01, e02, e10, e11, e12, e20, e21, e22 from bit 0 up, 16 bits each
    input  logic [m3i_pkg::IN_DATA_W-1:0]       s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22 from bit 0 up
    output logic [m3i_pkg::OUT_DATA_W-1:0]      m_tdata,
    // invertible
    output logic                                m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [m3i_pkg::MIN_DET_W-1:0]       cfg_data
);
    import m3i_pkg::*;

    logic [MIN_DET_W-1:0] min_det_reg;
    logic                 push_valid, push_ready;
    logic                 pop_valid, pop_ready;
    q_entry_t             push_entry, pop_entry;

    // cfg is always taken; the user must write it only while the core is idle; not enforced.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_det_reg <= MIN_DET_RST;
        else if (cfg_valid)
            min_det_reg <= cfg_data;
    end

    m3i_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (s_tdata),
        .min_det    (min_det_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    m3i_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    m3i_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_entry      (pop_entry),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_data       (m_tdata),
        .out_invertible (m_tuser)
    );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for matrix3x3_inverse_core: drives matrices, predicts each inverse.
// Depends on m3i_pkg and the RTL of the core; needs no files or arguments.
module testbench;

    import m3i_pkg::*;

    typedef struct {
        logic signed [31:0] inv [9];
        logic               invertible;
    } inverse_t;

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata;   // e00..e22 from bit 0 up
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_DATA_W-1:0]   m_tdata;   // inv00..inv22 from bit 0 up
    logic                    m_tuser;   // invertible
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [MIN_DET_W-1:0]    cfg_data;

    logic [MIN_DET_W-1:0]    thresh;
    inverse_t                pending_q [$];
    int                      errors;
    bit                      source_idle_en;
    bit                      sink_stall_en;

    matrix3x3_inverse_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Exact inverse: cofactors and determinant in wide signed integers, then a
    // truncating division with saturation to Q16.16.
    function automatic inverse_t invert_matrix(logic [IN_DATA_W-1:0] m);
        logic signed [63:0]  a [3][3];
        logic signed [63:0]  cof [3][3];
        logic signed [127:0] det;
        logic signed [127:0] dmag;
        logic signed [127:0] num;
        logic signed [127:0] quo;
        inverse_t            res;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                a[r][c] = $signed(m[(r*3+c)*ELEM_W +: ELEM_W]);
        cof[0][0] = a[1][1]*a[2][2] - a[1][2]*a[2][1];
        cof[0][1] = -(a[1][0]*a[2][2] - a[1][2]*a[2][0]);
        cof[0][2] = a[1][0]*a[2][1] - a[1][1]*a[2][0];
        cof[1][0] = -(a[0][1]*a[2][2] - a[0][2]*a[2][1]);
        cof[1][1] = a[0][0]*a[2][2] - a[0][2]*a[2][0];
        cof[1][2] = -(a[0][0]*a[2][1] - a[0][1]*a[2][0]);
        cof[2][0] = a[0][1]*a[1][2] - a[0][2]*a[1][1];
        cof[2][1] = -(a[0][0]*a[1][2] - a[0][2]*a[1][0]);
        cof[2][2] = a[0][0]*a[1][1] - a[0][1]*a[1][0];
        det = 128'(a[0][0])*cof[0][0] + 128'(a[0][1])*cof[0][1]
            + 128'(a[0][2])*cof[0][2];
        dmag = (det < 0) ? -det : det;
        res.invertible = (dmag != 0) && (dmag >= $signed({80'd0, thresh}));
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
            begin
                if (!res.invertible)
                    res.inv[r*3+c] = '0;
                else
                begin
                    num = 128'(cof[c][r]) <<< OUT_SHIFT;
                    quo = num / det;   // truncates toward zero
                    if (quo > 128'sd2147483647)
                        res.inv[r*3+c] = 32'h7FFFFFFF;
                    else if (quo < -128'sd2147483648)
                        res.inv[r*3+c] = 32'h80000000;
                    else
                        res.inv[r*3+c] = quo[31:0];
                end
            end
        return res;
    endfunction

    // Leaves tvalid high after the beat so that the next beat can follow at once;
    // an idle burst or a threshold write drops it.
    task automatic send_matrix(logic [IN_DATA_W-1:0] m);
        if (source_idle_en && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= m;
        pending_q.push_back(invert_matrix(m));
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Waits for every result, then lets the pipeline drain before writing.
    task automatic write_threshold(logic [MIN_DET_W-1:0] v);
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        thresh = v;
    endtask

    function automatic logic [IN_DATA_W-1:0] rand_matrix(int kind);
        logic [IN_DATA_W-1:0] m;
        for (int i = 0; i < 9; i++)
        begin
            case (kind)
                0: m[i*ELEM_W +: ELEM_W] = 16'($urandom);
                1: m[i*ELEM_W +: ELEM_W] = 16'($signed($urandom_range(0, 1023)) - 512);
                default: m[i*ELEM_W +: ELEM_W] = 16'($signed($urandom_range(0, 15)) - 8);
            endcase
        end
        // Sometimes make it near-diagonal so the inverse is well in range.
        if (kind == 3)
            for (int i = 0; i < 9; i += 4)
                m[i*ELEM_W +: ELEM_W] = 16'($urandom_range(64, 2048));
        return m;
    endfunction

    function automatic logic [IN_DATA_W-1:0] diag(logic [15:0] d0, logic [15:0] d1,
                                                  logic [15:0] d2);
        logic [IN_DATA_W-1:0] m;
        m = '0;
        m[0 +: 16]   = d0;
        m[64 +: 16]  = d1;
        m[128 +: 16] = d2;
        return m;
    endfunction

    task automatic test_directed;
        logic [IN_DATA_W-1:0] m;
        send_matrix(diag(16'h0100, 16'h0100, 16'h0100));   // identity
        send_matrix(diag(16'h0200, 16'hFF00, 16'h0080));
        send_matrix('0);                                    // zero determinant
        send_matrix('1);                                    // all -1 LSB, singular
        send_matrix(diag(16'h0001, 16'h0001, 16'h0001));   // det 1, below reset threshold
        send_matrix(diag(16'h0001, 16'h0001, 16'h0011));   // det equals threshold
        send_matrix(diag(16'h0001, 16'h0001, 16'h8000));   // most negative diagonal entry
        send_matrix(diag(16'h0001, 16'hFFFF, 16'h0100));   // negative determinant
        // Nearly singular 2x2 block (det -1) with e22 = -17, det 17: saturates both ways.
        m = diag(16'h7FFF, 16'h7FFD, 16'hFFEF);
        m[16 +: 16] = 16'h7FFE;
        m[48 +: 16] = 16'h7FFE;
        send_matrix(m);
        send_matrix(diag(16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_matrix(diag(16'h8000, 16'h8000, 16'h8000));
        send_matrix({9{16'h8000}});
        send_matrix({9{16'h7FFF}});
        m = diag(16'h7FFF, 16'h8000, 16'h7FFF);
        m[16 +: 16] = 16'h8000;
        m[48 +: 16] = 16'h7FFF;
        send_matrix(m);
        send_matrix({16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                     16'hAAAA, 16'h5555, 16'hAAAA, 16'h1234});
    endtask

    task automatic test_thresholds;
        write_threshold('0);   // only a zero determinant is singular
        send_matrix(diag(16'h0001, 16'h0001, 16'h0001));
        send_matrix('0);
        for (int i = 0; i < 20; i++)
            send_matrix(rand_matrix(2));
        write_threshold({1'b1, 47'd0});   // only the top bit set
        send_matrix({9{16'h7FFF}});
        send_matrix(diag(16'h8000, 16'h8000, 16'h8000));
        for (int i = 0; i < 20; i++)
            send_matrix(rand_matrix(0));
        write_threshold('1);
        for (int i = 0; i < 10; i++)
            send_matrix(rand_matrix(0));
        write_threshold(48'd16777216);   // one in Q.24
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
        begin
            if (i == 250)
                write_threshold(48'($urandom_range(0, 4096)));
            if (i == 400)
                write_threshold(48'd17);
            send_matrix(rand_matrix($urandom_range(0, 3)));
        end
    endtask

    task automatic test_no_idle(int n);
        source_idle_en = 1'b0;
        sink_stall_en  = 1'b0;
        for (int i = 0; i < n; i++)
            send_matrix(rand_matrix($urandom_range(0, 3)));
    endtask

    // Sink: random stall bursts while enabled.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (sink_stall_en && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // Result checker: every beat against the oldest expected inverse.
    always @(posedge clk)
    begin
        inverse_t exp_inv;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result beat %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                exp_inv = pending_q.pop_front();
                for (int i = 0; i < 9; i++)
                    if (m_tdata[i*OUT_W +: OUT_W] !== exp_inv.inv[i])
                    begin
                        $display("%0t: inv%0d%0d expected %h actual %h", $time,
                                 i / 3, i % 3, exp_inv.inv[i], m_tdata[i*OUT_W +: OUT_W]);
                        errors++;
                    end
                if (m_tuser !== exp_inv.invertible)
                begin
                    $display("%0t: invertible expected %b actual %b", $time,
                             exp_inv.invertible, m_tuser);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("testbench failed");
        $finish;
    end

    initial
    begin
        errors         = 0;
        thresh         = 48'd17;
        source_idle_en = 1'b1;
        sink_stall_en  = 1'b1;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_thresholds();
        test_random(500);
        test_no_idle(80);
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
